// ----- hdl/bpc_pkg.sv -----
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [19:0]        pressure;
    logic               divide_error;
  } out_word_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrW = 5;

  localparam logic [AddrW-1:0] AddrCalA = 5'd0;
  localparam logic [AddrW-1:0] AddrCalB = 5'd8;
  localparam logic [AddrW-1:0] AddrCalC = 5'd16;
  localparam logic [AddrW-1:0] AddrOss  = 5'd24;

  typedef enum logic [4:0] {
    ST_IDLE, ST_X1A, ST_X1B, ST_DEN, ST_DIV1, ST_B5, ST_SQA, ST_SQB,
    ST_P1A, ST_P1B, ST_B3A, ST_B3B, ST_B4A, ST_B4B, ST_B4C, ST_B7,
    ST_DIV2, ST_PA, ST_PB, ST_PC, ST_PD, ST_OUT
  } state_e;

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_e;

endpackage

// ----- hdl/barometric_pressure_compensation_unit.sv -----
// channel | direction | handshake
// in      | input     | push / full
// result  | output    | empty / pop
// config  | input     | APB psel/penable/pwrite, pready high
// Each item runs through the back sequencer, including two
// radix-2 divisions (load, 32 steps, done). A zero first divisor or a zero
// b4 ends an item early and skips the division by zero.
// Reset clears queue, sequencer and all calibration registers.
// A waiting result holds the sequencer idle; the two-word input queue keeps
// accepting until it fills and raises full.
module barometric_pressure_compensation_unit #(
  parameter int unsigned QueueDepth = bpc_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  bpc_pkg::in_word_t   in_word_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output bpc_pkg::out_word_t  out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [bpc_pkg::AddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;
  logic avail, take, res_valid;
  bpc_pkg::in_word_t qword;
  logic [31:0] up;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q <= '0;
    end else if (wr) begin
      unique case (paddr)
        bpc_pkg::AddrCalA: cal_a_q <= pwdata;
        bpc_pkg::AddrCalB: cal_b_q <= pwdata;
        bpc_pkg::AddrCalC: cal_c_q <= pwdata[31:0];
        bpc_pkg::AddrOss:  oss_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      bpc_pkg::AddrCalA: prdata = cal_a_q;
      bpc_pkg::AddrCalB: prdata = cal_b_q;
      bpc_pkg::AddrCalC: prdata = {32'd0, cal_c_q};
      bpc_pkg::AddrOss:  prdata = {62'd0, oss_q};
      default:           prdata = '0;
    endcase
  end

  bpc_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .push_i(push), .word_i(in_word_i), .full_o(full),
    .oss_i(oss_q), .take_i(take), .avail_o(avail), .word_o(qword), .up_o(up)
  );

  bpc_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .word_i(qword), .up_i(up), .take_o(take),
    .cal_a_i(cal_a_q), .cal_b_i(cal_b_q), .cal_c_i(cal_c_q), .oss_i(oss_q),
    .res_valid_o(res_valid), .res_o(out_word_o), .res_pop_i(pop && !empty)
  );

  assign empty = !res_valid;
endmodule

// ----- hdl/bpc_divider.sv -----
module bpc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  bpc_pkg::div_state_e state_q, state_d;
  logic [31:0] q_q, q_d, r_q, r_d, d_q;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::DIV_IDLE: if (start_i) state_d = bpc_pkg::DIV_RUN;
      bpc_pkg::DIV_RUN:  if (cnt_q == 5'd0) state_d = bpc_pkg::DIV_DONE;
      bpc_pkg::DIV_DONE: state_d = bpc_pkg::DIV_IDLE;
      default:           state_d = bpc_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    trial = {r_q, q_q[31]} - {1'b0, d_q};
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    if (state_q == bpc_pkg::DIV_IDLE) begin
      q_d = dividend_i;
      r_d = '0;
      cnt_d = 5'd31;
    end else if (state_q == bpc_pkg::DIV_RUN) begin
      cnt_d = cnt_q - 5'd1;
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::DIV_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (state_q == bpc_pkg::DIV_IDLE) d_q <= divisor_i;
  end

  assign done_o = (state_q == bpc_pkg::DIV_DONE);
  assign quotient_o = q_q;
endmodule

// ----- hdl/bpc_front.sv -----
module bpc_front #(
  parameter int unsigned Depth = bpc_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpc_pkg::in_word_t  word_i,
  output logic               full_o,
  input  logic [1:0]         oss_i,
  input  logic               take_i,
  output logic               avail_o,
  output bpc_pkg::in_word_t  word_o,
  output logic [31:0]        up_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  bpc_pkg::in_word_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && avail_o;
  assign word_o  = mem_q[rp_q];
  assign up_o    = {8'd0, word_o.raw_pressure >> (4'd8 - {2'd0, oss_i})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= word_i;
  end
endmodule

// ----- hdl/bpc_back.sv -----
module bpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  bpc_pkg::in_word_t   word_i,
  input  logic [31:0]         up_i,
  output logic                take_o,
  input  logic [63:0]         cal_a_i,
  input  logic [63:0]         cal_b_i,
  input  logic [31:0]         cal_c_i,
  input  logic [1:0]          oss_i,
  output logic                res_valid_o,
  output bpc_pkg::out_word_t  res_o,
  input  logic                res_pop_i
);
  bpc_pkg::state_e state_q, state_d;
  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic signed [31:0] ut_q, up_q, x1_q, x2_q, x3_q, b6_q, sq_q, b3_q, t_q, p_q;
  logic signed [31:0] m_q;
  logic [31:0] b4_q, b7_q, pu, b7;
  logic signed [31:0] num_q, den_q;
  logic neg_q, div_start, div_done, err_q;
  logic [31:0] dvd, dvs, quo;
  logic signed [31:0] t_sat;
  logic [19:0] p_sat;
  bpc_pkg::out_word_t res_q;
  logic res_v_q;

  assign ac1 = 32'(signed'(cal_a_i[63:48]));
  assign ac2 = 32'(signed'(cal_a_i[47:32]));
  assign ac3 = 32'(signed'(cal_a_i[31:16]));
  assign ac4 = {16'd0, cal_a_i[15:0]};
  assign ac5 = {16'd0, cal_b_i[63:48]};
  assign ac6 = {16'd0, cal_b_i[47:32]};
  assign b1  = 32'(signed'(cal_b_i[31:16]));
  assign b2  = 32'(signed'(cal_b_i[15:0]));
  assign mc  = 32'(signed'(cal_c_i[31:16]));
  assign md  = 32'(signed'(cal_c_i[15:0]));

  assign dvd = num_q;
  assign dvs = den_q;
  bpc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(div_done), .quotient_o(quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: if (avail_i && (!res_v_q || res_pop_i)) state_d = bpc_pkg::ST_X1A;
      bpc_pkg::ST_X1A:  state_d = bpc_pkg::ST_X1B;
      bpc_pkg::ST_X1B:  state_d = bpc_pkg::ST_DEN;
      bpc_pkg::ST_DEN:  state_d = (x2_q == 0) ? bpc_pkg::ST_OUT : bpc_pkg::ST_DIV1;
      bpc_pkg::ST_DIV1: if (div_done) state_d = bpc_pkg::ST_B5;
      bpc_pkg::ST_B5:   state_d = bpc_pkg::ST_SQA;
      bpc_pkg::ST_SQA:  state_d = bpc_pkg::ST_SQB;
      bpc_pkg::ST_SQB:  state_d = bpc_pkg::ST_P1A;
      bpc_pkg::ST_P1A:  state_d = bpc_pkg::ST_P1B;
      bpc_pkg::ST_P1B:  state_d = bpc_pkg::ST_B3A;
      bpc_pkg::ST_B3A:  state_d = bpc_pkg::ST_B3B;
      bpc_pkg::ST_B3B:  state_d = bpc_pkg::ST_B4A;
      bpc_pkg::ST_B4A:  state_d = bpc_pkg::ST_B4B;
      bpc_pkg::ST_B4B:  state_d = bpc_pkg::ST_B4C;
      bpc_pkg::ST_B4C:  state_d = (b4_q == 0) ? bpc_pkg::ST_OUT : bpc_pkg::ST_B7;
      bpc_pkg::ST_B7:   state_d = bpc_pkg::ST_DIV2;
      bpc_pkg::ST_DIV2: if (div_done) state_d = bpc_pkg::ST_PA;
      bpc_pkg::ST_PA:   state_d = bpc_pkg::ST_PB;
      bpc_pkg::ST_PB:   state_d = bpc_pkg::ST_PC;
      bpc_pkg::ST_PC:   state_d = bpc_pkg::ST_PD;
      bpc_pkg::ST_PD:   state_d = bpc_pkg::ST_OUT;
      bpc_pkg::ST_OUT:  state_d = bpc_pkg::ST_IDLE;
      default:          state_d = bpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take_o = (state_q == bpc_pkg::ST_IDLE) && avail_i && (!res_v_q || res_pop_i);
    div_start = (state_q == bpc_pkg::ST_DIV1) || (state_q == bpc_pkg::ST_DIV2);
  end

  assign pu = b7_q[31] ? {quo[30:0], 1'b0} : quo;
  assign b7 = (up_q - b3_q) * (32'd50000 >> oss_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::ST_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bpc_pkg::ST_OUT) res_v_q <= 1'b1;
      else if (res_pop_i) res_v_q <= 1'b0;
    end
  end

  always_comb begin
    t_sat = (t_q > 32767) ? 32'sd32767 : (t_q < -32768) ? -32'sd32768 : t_q;
    p_sat = (p_q > 1048575) ? 20'hFFFFF : (p_q < 0) ? 20'd0 : p_q[19:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bpc_pkg::ST_IDLE: begin
        ut_q <= {16'd0, word_i.raw_temperature};
        up_q <= up_i;
        err_q <= 1'b0;
      end
      bpc_pkg::ST_X1A: m_q <= (ut_q - ac6) * ac5;
      bpc_pkg::ST_X1B: begin
        x1_q <= m_q >>> 15;
        x2_q <= (m_q >>> 15) + md;
      end
      bpc_pkg::ST_DEN: begin
        err_q <= (x2_q == 0);
        neg_q <= mc[31] ^ x2_q[31];
        num_q <= mc[31] ? -(mc <<< 11) : (mc <<< 11);
        den_q <= x2_q[31] ? -x2_q : x2_q;
      end
      bpc_pkg::ST_DIV1: if (div_done) x3_q <= neg_q ? -quo : quo;
      bpc_pkg::ST_B5: begin
        t_q <= (x1_q + x3_q + 8) >>> 4;
        b6_q <= x1_q + x3_q - 4000;
      end
      bpc_pkg::ST_SQA: m_q <= b6_q * b6_q;
      bpc_pkg::ST_SQB: begin
        sq_q <= m_q >>> 12;
        m_q <= ac2 * b6_q;
      end
      bpc_pkg::ST_P1A: begin
        x2_q <= m_q >>> 11;
        m_q <= b2 * sq_q;
      end
      bpc_pkg::ST_P1B: begin
        x1_q <= m_q >>> 11;
        m_q <= ac3 * b6_q;
      end
      bpc_pkg::ST_B3A: begin
        b3_q <= (((ac1 <<< 2) + x1_q + x2_q) <<< oss_i) + 2;
        x1_q <= m_q >>> 13;
        m_q <= b1 * sq_q;
      end
      bpc_pkg::ST_B3B: begin
        b3_q <= (b3_q < 0) ? -((-b3_q) >> 2) : (b3_q >>> 2);
        x3_q <= (x1_q + (m_q >>> 16) + 2) >>> 2;
      end
      bpc_pkg::ST_B4A: m_q <= ac4 * (x3_q + 32768);
      bpc_pkg::ST_B4B: b4_q <= 32'(m_q) >> 15;
      bpc_pkg::ST_B4C: err_q <= (b4_q == 0);
      // b7 msb set: quotient of b7 itself, doubled afterwards
      bpc_pkg::ST_B7: begin
        b7_q <= b7;
        num_q <= b7[31] ? b7 : {b7[30:0], 1'b0};
        den_q <= b4_q;
      end
      bpc_pkg::ST_DIV2: if (div_done) p_q <= pu;
      bpc_pkg::ST_PA: m_q <= (p_q >>> 8) * (p_q >>> 8);
      bpc_pkg::ST_PB: begin
        x1_q <= m_q * 3038;
        m_q <= -7357 * p_q;
      end
      bpc_pkg::ST_PC: begin
        x1_q <= x1_q >>> 16;
        x2_q <= m_q >>> 16;
      end
      bpc_pkg::ST_PD: p_q <= p_q + ((x1_q + x2_q + 3791) >>> 4);
      bpc_pkg::ST_OUT: begin
        res_q.divide_error <= err_q;
        res_q.temperature <= err_q ? 16'sd0 : t_sat[15:0];
        res_q.pressure <= err_q ? 20'd0 : p_sat;
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_v_q;
  assign res_o = res_q;
endmodule

// ----- hdl/bpc_checker.sv -----
module bpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic full,
  input logic pready,
  input bpc_pkg::out_word_t out_word_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o))) else $error("result lost");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.divide_error) |-> (out_word_o.pressure == 0 &&
    out_word_o.temperature == 0)) else $error("error result not zero");
  a_rdy: assert property (@(posedge clk_i) pready) else $error("pready low");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("reset state");
endmodule

bind barometric_pressure_compensation_unit bpc_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .full, .pready, .out_word_o
);

// ----- tb/sv/tb_barometric_pressure_compensation_unit.sv -----
`timescale 1ns / 100ps

module tb_barometric_pressure_compensation_unit;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  bpc_pkg::in_word_t in_word_i = '0;
  logic full, empty;
  logic pop = 1'b0;
  bpc_pkg::out_word_t out_word_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bpc_pkg::AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  barometric_pressure_compensation_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // calibration held by the predictor
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_q;

  bpc_pkg::out_word_t expected_words[$];
  int errors = 0;
  bit hold_pop = 1'b0;

  function automatic logic signed [31:0] sdiv(logic signed [31:0] a, logic signed [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    if (a[31] != b[31]) q = -q;
    return q;
  endfunction

  function automatic bpc_pkg::out_word_t compensate(bpc_pkg::in_word_t w);
    bpc_pkg::out_word_t r;
    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, t, p, q;
    logic [31:0] b4, b7, pu;
    ac1 = $signed(cal_a[63:48]); ac2 = $signed(cal_a[47:32]);
    ac3 = $signed(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = $signed(cal_b[31:16]); b2 = $signed(cal_b[15:0]);
    mc = $signed(cal_c[31:16]); md = $signed(cal_c[15:0]);
    ut = {16'd0, w.raw_temperature};
    up = {8'd0, w.raw_pressure} >> (8 - oss_q);
    r = '0;
    x1 = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    x2 = sdiv(mc <<< 11, den);
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = sdiv((((ac1 * 4) + x3) <<< oss_q) + 2, 4);
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * (x3 + 32768)) >> 15;
    if (b4 == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss_q);
    pu = b7[31] ? (b7 / b4) * 2 : (b7 * 2) / b4;
    p = pu;
    q = p >>> 8;
    x1 = ((q * q) * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p > 1048575) p = 1048575;
    if (p < 0) p = 0;
    r.temperature = t[15:0];
    r.pressure = p[19:0];
    return r;
  endfunction

  task automatic reg_write(logic [bpc_pkg::AddrW-1:0] a, logic [63:0] d);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (a)
      bpc_pkg::AddrCalA: cal_a = d;
      bpc_pkg::AddrCalB: cal_b = d;
      bpc_pkg::AddrCalC: cal_c = d[31:0];
      bpc_pkg::AddrOss:  oss_q = d[1:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // full only moves at rising edges, so its value at the falling edge decides
  task automatic send_word(bpc_pkg::in_word_t w);
    @(negedge clk_i);
    push <= 1'b1;
    in_word_i <= w;
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    expected_words.push_back(compensate(w));
  endtask

  task automatic send_gap();
    int g;
    g = $urandom_range(0, 99) < 90 ? $urandom_range(0, 2) : $urandom_range(10, 120);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int n, bit gaps);
    bpc_pkg::in_word_t w;
    repeat (n) begin
      w.raw_temperature = 16'($urandom());
      w.raw_pressure = 24'($urandom());
      send_word(w);
      if (gaps) send_gap();
    end
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic random_cal();
    reg_write(bpc_pkg::AddrCalA, {$urandom(), $urandom()});
    reg_write(bpc_pkg::AddrCalB, {$urandom(), $urandom()});
    reg_write(bpc_pkg::AddrCalC, {32'd0, $urandom()});
    reg_write(bpc_pkg::AddrOss, 64'($urandom_range(0, 3)));
  endtask

  // realistic coefficient set, nearby variations keep both divisions live
  task automatic typical_cal(logic [1:0] o);
    reg_write(bpc_pkg::AddrCalA, {16'sd408, -16'sd72, -16'sd14383, 16'd32741});
    reg_write(bpc_pkg::AddrCalB, {16'd32757, 16'd23153, 16'sd6190, 16'sd4});
    reg_write(bpc_pkg::AddrCalC, {32'd0, -16'sd8711, 16'sd2868});
    reg_write(bpc_pkg::AddrOss, 64'(o));
  endtask

  typedef struct {
    bpc_pkg::in_word_t  w;
    bit                 known;
    bpc_pkg::out_word_t r;
  } stim_row_t;

  task automatic run_rows(stim_row_t rows[$]);
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].known) expected_words[$] = rows[i].r;
    end
    @(negedge clk_i) push <= 1'b0;
    drain_and_settle();
  endtask

  // pop side with random stalls and checking
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: %p", out_word_o);
        errors++;
      end else begin
        bpc_pkg::out_word_t e;
        e = expected_words.pop_front();
        if (out_word_o.temperature !== e.temperature) begin
          $error("temperature exp %0d got %0d", e.temperature, out_word_o.temperature);
          errors++;
        end
        if (out_word_o.pressure !== e.pressure) begin
          $error("pressure exp %0d got %0d", e.pressure, out_word_o.pressure);
          errors++;
        end
        if (out_word_o.divide_error !== e.divide_error) begin
          $error("divide_error exp %0b got %0b", e.divide_error, out_word_o.divide_error);
          errors++;
        end
      end
    end
  end

  initial begin
    int s;
    forever begin
      @(negedge clk_i);
      if (hold_pop) begin
        pop <= 1'b0;
      end else if ($urandom_range(0, 99) < 5) begin
        pop <= 1'b0;
        s = $urandom_range(0, 99) < 85 ? $urandom_range(1, 3) : $urandom_range(20, 150);
        repeat (s - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    cal_a = '0; cal_b = '0; cal_c = '0; oss_q = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // after reset every word reports a zero divisor
    row.known = 1'b1; row.r = '0; row.r.divide_error = 1'b1;
    row.w = '0; rows.push_back(row);
    row.w = '1; rows.push_back(row);
    row.w = {16'h5555, 24'haaaaaa}; rows.push_back(row);
    run_rows(rows);

    for (int o = 0; o < 4; o++) begin
      typical_cal(o[1:0]);
      rows.delete();
      row.known = 1'b0;
      row.w = {16'd27898, 24'd23843 << 8}; rows.push_back(row);
      row.w = '0; rows.push_back(row);
      row.w = '1; rows.push_back(row);
      row.w = {16'hffff, 24'd0}; rows.push_back(row);
      row.w = {16'd0, 24'hffffff}; rows.push_back(row);
      run_rows(rows);
    end

    // b4 zero: ac4 = 0
    reg_write(bpc_pkg::AddrCalA, {16'sd408, -16'sd72, -16'sd14383, 16'd0});
    send_random(4, 1'b0);
    drain_and_settle();
    // extreme coefficients
    reg_write(bpc_pkg::AddrCalA, '1);
    reg_write(bpc_pkg::AddrCalB, '1);
    reg_write(bpc_pkg::AddrCalC, 64'hffff_ffff_8000_7fff);
    reg_write(bpc_pkg::AddrOss, 64'd3);
    send_random(6, 1'b0);
    drain_and_settle();
    reg_write(bpc_pkg::AddrCalA, 64'h8000_8000_8000_ffff);
    reg_write(bpc_pkg::AddrCalB, 64'hffff_0000_8000_8000);
    reg_write(bpc_pkg::AddrCalC, 64'h8000_8000);
    send_random(6, 1'b0);
    drain_and_settle();

    // back-pressure: output stalled while input keeps offering
    typical_cal(2'd1);
    hold_pop = 1'b1;
    fork
      send_random(12, 1'b0);
      begin
        repeat (600) @(negedge clk_i);
        hold_pop = 1'b0;
      end
    join
    drain_and_settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) random_cal();
      else begin
        typical_cal(2'($urandom_range(0, 3)));
        reg_write(bpc_pkg::AddrCalC, {32'd0, 16'($urandom_range(0, 65535)) | 16'h8000,
                                      16'($urandom_range(0, 6000))});
      end
      send_random(200, 1'b1);
      drain_and_settle();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
